// ===== rtl/imtq_pkg.sv =====
// Shared types, constants and handshake structs for the indexed minimum tournament queue.
package imtq_pkg;

    localparam int CAPACITY  = 1024;
    localparam int KEY_WIDTH = 32;
    localparam int LEAF_W    = $clog2(CAPACITY);
    localparam int LEAVES    = 1 << LEAF_W;
    localparam int NODE_W    = LEAF_W + 1;
    localparam int NODES     = 2 * LEAVES;
    localparam int OP_W      = 2;
    localparam int ID_W      = 11;

    typedef logic [KEY_WIDTH-1:0] t_key;
    typedef logic [OP_W-1:0]      t_op;
    typedef logic [NODE_W-1:0]    t_node;
    typedef logic [LEAF_W-1:0]    t_leaf;

    localparam t_op OP_DECREASE = 2'd0;
    localparam t_op OP_DELETE   = 2'd1;
    localparam t_op OP_QUERY    = 2'd2;

    typedef struct packed {
        logic  present;
        t_leaf idx;
        t_key  key;
    } t_entry;

    typedef struct packed {
        logic capture;
        logic clr_step;
        logic look;
        logic ins_leaf;
        logic del_leaf;
        logic climb;
        logic query;
        logic emit;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic id_ok;
        logic leaf_le;
        logic root_present;
        logic at_top;
        logic clr_last;
        logic out_free;
    } t_sts;

endpackage

// ===== rtl/imtq_ctrl.sv =====
// Sequencer for the tournament queue: clearing pass, dispatch, leaf update, tree climb, result.
module imtq_ctrl import imtq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    input  t_sts i_sts,
    output logic o_ready,
    output t_cmd o_cmd
);

    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_DISPATCH = 3'd2;
    localparam logic [2:0] S_DECIDE   = 3'd3;
    localparam logic [2:0] S_CLIMB    = 3'd4;
    localparam logic [2:0] S_DONE     = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    assign o_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                priority if ((i_sts.op == OP_DECREASE || i_sts.op == OP_QUERY) && i_sts.id_ok) begin
                    o_cmd.look = 1'b1;
                    n_state    = S_DECIDE;
                end else if (i_sts.op == OP_DELETE && i_sts.root_present) begin
                    o_cmd.del_leaf = 1'b1;
                    n_state        = S_CLIMB;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DECIDE: begin
                priority if (i_sts.op == OP_QUERY) begin
                    o_cmd.query = 1'b1;
                    n_state     = S_DONE;
                end else if (i_sts.leaf_le) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.ins_leaf = 1'b1;
                    n_state        = S_CLIMB;
                end
            end
            S_CLIMB: begin
                o_cmd.climb = 1'b1;
                if (i_sts.at_top) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== rtl/imtq_dp.sv =====
// Datapath: tree memory, path registers, root copy and the result register.
module imtq_dp import imtq_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_op             i_opcode,
    input  logic [ID_W-1:0] i_node_id,
    input  t_key            i_key_value,
    input  logic            i_out_ready,
    input  t_cmd            i_cmd,
    output t_sts            o_sts,
    output logic            o_valid,
    output logic            o_accepted,
    output logic            o_query_present,
    output t_key            o_query_value,
    output logic [ID_W-1:0] o_min_id,
    output t_key            o_min_value,
    output logic            o_is_empty
);

    t_entry r_mem [0:NODES-1];
    t_entry r_rdata;

    t_op    r_op;
    logic   r_id_ok;
    t_leaf  r_leaf;
    t_key   r_key;
    t_node  r_node;
    t_entry r_win;
    t_entry r_root;
    t_node  r_clr;
    logic   r_acc;
    logic   r_qp;
    t_key   r_qv;
    logic   r_out_valid;

    logic   mem_we;
    t_node  mem_waddr;
    t_entry mem_wdata;
    t_node  mem_raddr;

    t_node  leaf_node;
    t_node  new_node;
    t_entry new_entry;
    t_node  parent;
    t_entry left_e;
    t_entry right_e;
    t_entry best;

    assign leaf_node = {1'b1, r_leaf};
    assign new_node  = i_cmd.del_leaf ? {1'b1, r_root.idx} : leaf_node;
    assign parent    = {1'b0, r_node[NODE_W-1:1]};

    always_comb begin
        new_entry.present = !i_cmd.del_leaf;
        new_entry.idx     = i_cmd.del_leaf ? r_root.idx : r_leaf;
        new_entry.key     = r_key;
    end

    assign left_e  = r_node[0] ? r_rdata : r_win;
    assign right_e = r_node[0] ? r_win : r_rdata;
    assign best    = (right_e.present && (!left_e.present || right_e.key < left_e.key))
                     ? right_e : left_e;

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_clr;
        mem_wdata = '0;
        mem_raddr = leaf_node;
        priority if (i_cmd.clr_step) begin
            mem_we = 1'b1;
        end else if (i_cmd.ins_leaf || i_cmd.del_leaf) begin
            mem_we    = 1'b1;
            mem_waddr = new_node;
            mem_wdata = new_entry;
            mem_raddr = new_node ^ NODE_W'(1);
        end else if (i_cmd.climb) begin
            mem_we    = 1'b1;
            mem_waddr = parent;
            mem_wdata = best;
            mem_raddr = parent ^ NODE_W'(1);
        end else if (i_cmd.look) begin
            mem_raddr = leaf_node;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op    <= i_opcode;
            r_id_ok <= (i_node_id >= ID_W'(1)) && (i_node_id <= ID_W'(CAPACITY));
            r_leaf  <= LEAF_W'(i_node_id - ID_W'(1));
            r_key   <= i_key_value;
            r_acc   <= 1'b0;
            r_qp    <= 1'b0;
            r_qv    <= '0;
        end
        if (i_cmd.ins_leaf) begin
            r_acc <= 1'b1;
        end
        if (i_cmd.query) begin
            r_qp <= r_rdata.present;
            r_qv <= r_rdata.present ? r_rdata.key : '0;
        end
        if (i_cmd.ins_leaf || i_cmd.del_leaf) begin
            r_node <= new_node;
            r_win  <= new_entry;
        end else if (i_cmd.climb) begin
            r_node <= parent;
            r_win  <= best;
        end
        if (i_cmd.emit) begin
            o_accepted      <= r_acc;
            o_query_present <= r_qp;
            o_query_value   <= r_qv;
            o_min_id        <= r_root.present ? ID_W'({1'b0, r_root.idx} + NODE_W'(1))
                                              : ID_W'(1);
            o_min_value     <= r_root.present ? r_root.key : '0;
            o_is_empty      <= !r_root.present;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_root      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + NODE_W'(1);
            end
            if (i_cmd.climb && parent == NODE_W'(1)) begin
                r_root <= best;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;

    always_comb begin
        o_sts.op           = r_op;
        o_sts.id_ok        = r_id_ok;
        o_sts.leaf_le      = r_rdata.present && (r_rdata.key <= r_key);
        o_sts.root_present = r_root.present;
        o_sts.at_top       = (parent == NODE_W'(1));
        o_sts.clr_last     = (r_clr == NODE_W'(NODES - 1));
        o_sts.out_free     = !r_out_valid || i_out_ready;
    end

endmodule

// ===== rtl/indexed_min_tournament_queue_top.sv =====
// Top level of the indexed minimum tournament queue: controller and datapath.
//
// Indexed min priority queue over node ids 1..1024 held as a tournament tree in one
// 2048-entry memory (leaves and internal winners, each carrying its winner's key).
// After reset a clearing pass over every memory entry runs before the first beat is taken.
// One operation is worked at a time. A decrease that changes the tree and a delete of
// the minimum write a leaf and then climb to the root; a query or a decrease that
// changes nothing reads its leaf only, and a delete on an empty queue, an unused
// opcode or a node id out of range goes straight to the result. The climb moves
// one tree level per cycle over the memory's single read and write port, ten levels.
// A finished result waits in the output register while the next beat is taken.
module indexed_min_tournament_queue_top import imtq_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  t_op             i_opcode,
    input  logic [ID_W-1:0] i_node_id,
    input  t_key            i_key_value,
    output logic            o_valid,
    input  logic            i_ready,
    output logic            o_accepted,
    output logic            o_query_present,
    output t_key            o_query_value,
    output logic [ID_W-1:0] o_min_id,
    output t_key            o_min_value,
    output logic            o_is_empty
);

    t_cmd cmd;
    t_sts sts;

    imtq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_ready (o_ready),
        .o_cmd   (cmd)
    );

    imtq_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_opcode        (i_opcode),
        .i_node_id       (i_node_id),
        .i_key_value     (i_key_value),
        .i_out_ready     (i_ready),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .o_valid         (o_valid),
        .o_accepted      (o_accepted),
        .o_query_present (o_query_present),
        .o_query_value   (o_query_value),
        .o_min_id        (o_min_id),
        .o_min_value     (o_min_value),
        .o_is_empty      (o_is_empty)
    );

endmodule

// ===== rtl/imtq_checker.sv =====
// Port-level checker for the tournament queue and its bind to the top level.
module imtq_checker import imtq_pkg::*; (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_valid,
    input logic            o_ready,
    input logic            o_valid,
    input logic            i_ready,
    input logic            o_accepted,
    input logic            o_query_present,
    input t_key            o_query_value,
    input logic [ID_W-1:0] o_min_id,
    input t_key            o_min_value,
    input logic            o_is_empty
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_min_id) && $stable(o_min_value))
        else $error("result beat changed while stalled");

    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_empty |-> o_min_value == '0 && o_min_id == ID_W'(1))
        else $error("empty queue reports a minimum");

    a_absent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_query_present |-> o_query_value == '0)
        else $error("absent node reports a key");

    a_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_accepted |-> !o_is_empty && !o_query_present)
        else $error("accepted decrease left queue empty");

    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("second beat taken while busy");

endmodule

bind indexed_min_tournament_queue_top imtq_checker u_imtq_checker (.*);
